### rtl/smmba_pkg.sv
// Shared codes, command and status bundles for the stack arithmetic unit.
package smmba_pkg;

  // Operation codes on func
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_MUL    = 2'd1;
  localparam logic [1:0] FUNC_MOD    = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_SHORT    = 2'd1;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd2;
  localparam logic [1:0] STAT_FULL     = 2'd3;

  // Word width and divider step count
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'd31;

  // Controller to datapath
  typedef struct packed {
    logic       capture;     // latch the request
    logic       set_status;  // load status_code into the status register
    logic [1:0] status_code;
    logic       wr_append;   // write value under the bottom word
    logic       rd_second;   // read the word below the top
    logic       mul_load;    // register second * top
    logic       div_load;    // start the remainder unit
    logic       div_step;    // one quotient bit
    logic       wb;          // write back the result and pop
    logic       load_out;    // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       full;
    logic       short;
    logic       top_zero;
    logic       div_last;
  } sts_t;

endpackage

### rtl/smmba_dp.sv
// Datapath: ring storage, pointers, multiplier, remainder unit and output register.
module smmba_dp #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  smmba_pkg::cmd_t      cmd_i,
  output smmba_pkg::sts_t      sts_o,
  input  logic [1:0]           func_i,
  input  logic signed [31:0]   value_i,
  output logic [1:0]           status_o,
  output logic signed [31:0]   top_word_o,
  output logic [6:0]           depth_o
);
  import smmba_pkg::*;

  localparam int unsigned PtrW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] mem [STACK_DEPTH];

  logic [1:0]          func_q;
  logic [WORD_W-1:0]   value_q;
  logic [PtrW-1:0]     ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic [WORD_W-1:0]   top_q;
  logic [1:0]          status_q;
  logic [WORD_W-1:0]   rd_q;
  logic [WORD_W-1:0]   prod_q;
  logic [WORD_W-1:0]   rem_q;
  logic [WORD_W-1:0]   dvd_q;
  logic [WORD_W-1:0]   dvs_q;
  logic                neg_q;
  logic [DIV_CNT_W-1:0] step_q;
  logic [1:0]          out_status_q;
  logic [WORD_W-1:0]   out_top_q;
  logic [6:0]          out_depth_q;

  logic [CntW:0]       bot_diff;
  logic [PtrW-1:0]     bot_idx;
  logic [PtrW-1:0]     s_idx;
  logic [WORD_W-1:0]   shifted;
  logic [WORD_W:0]     trial;
  logic [WORD_W-1:0]   result;
  logic [WORD_W-1:0]   mag_a;
  logic [WORD_W-1:0]   mag_b;
  logic                mem_we;
  logic [PtrW-1:0]     mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  // Bottom slot: top pointer minus count, wrapped into the ring
  always_comb begin
    bot_diff = (CntW+1)'(ptr_q) - {1'b0, cnt_q};
    if (bot_diff[CntW]) begin
      bot_diff = bot_diff + (CntW+1)'(STACK_DEPTH);
    end
    bot_idx = bot_diff[PtrW-1:0];
  end

  assign s_idx = (ptr_q == '0) ? PtrW'(STACK_DEPTH - 1) : ptr_q - 1'b1;

  // Restoring remainder step on magnitudes
  assign shifted = {rem_q[WORD_W-2:0], dvd_q[WORD_W-1]};
  assign trial   = {1'b0, shifted} - {1'b0, dvs_q};
  assign mag_a   = rd_q[WORD_W-1] ? (WORD_W'(0) - rd_q) : rd_q;
  assign mag_b   = top_q[WORD_W-1] ? (WORD_W'(0) - top_q) : top_q;

  assign result = (func_q == FUNC_MUL) ? prod_q : (neg_q ? (WORD_W'(0) - rem_q) : rem_q);

  assign mem_we    = cmd_i.wr_append | cmd_i.wb;
  assign mem_waddr = cmd_i.wb ? s_idx : bot_idx;
  assign mem_wdata = cmd_i.wb ? result : value_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_second) begin
      rd_q <= mem[s_idx];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.wr_append) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.wb) begin
      ptr_q <= s_idx;
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      value_q <= value_i;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
    if (cmd_i.wr_append && cnt_q == '0) begin
      top_q <= value_q;
    end else if (cmd_i.wb) begin
      top_q <= result;
    end
    if (cmd_i.mul_load) begin
      prod_q <= rd_q * top_q;
    end
    if (cmd_i.div_load) begin
      rem_q  <= '0;
      dvd_q  <= mag_a;
      dvs_q  <= mag_b;
      neg_q  <= rd_q[WORD_W-1];
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= trial[WORD_W] ? shifted : trial[WORD_W-1:0];
      dvd_q  <= {dvd_q[WORD_W-2:0], 1'b0};
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_top_q    <= (cnt_q == '0) ? '0 : top_q;
      out_depth_q  <= 7'(cnt_q);
    end
  end

  assign sts_o.func     = func_q;
  assign sts_o.full     = (cnt_q == CntW'(STACK_DEPTH));
  assign sts_o.short    = (cnt_q < CntW'(2));
  assign sts_o.top_zero = (top_q == '0);
  assign sts_o.div_last = (step_q == DIV_LAST_STEP);

  assign status_o   = out_status_q;
  assign top_word_o = out_top_q;
  assign depth_o    = out_depth_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(STACK_DEPTH))
    else $error("word count beyond capacity");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrW'(STACK_DEPTH - 1))
    else $error("top pointer outside ring");

  a_wb_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("write-back did not pop one word");

endmodule

### rtl/smmba_ctrl.sv
// Controller: sequences one request through check, read, compute and write-back.
module smmba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  smmba_pkg::sts_t sts_i,
  output smmba_pkg::cmd_t cmd_o
);
  import smmba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_DIV,
    S_WB,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.set_status  = 1'b1;
        cmd_o.status_code = STAT_OK;
        state_d           = S_DONE;
        unique case (sts_i.func) inside
          FUNC_APPEND: begin
            if (sts_i.full) begin
              cmd_o.status_code = STAT_FULL;
            end else begin
              cmd_o.wr_append = 1'b1;
            end
          end
          FUNC_MUL, FUNC_MOD: begin
            if (sts_i.short) begin
              cmd_o.status_code = STAT_SHORT;
            end else if (sts_i.func == FUNC_MOD && sts_i.top_zero) begin
              cmd_o.status_code = STAT_DIV_ZERO;
            end else begin
              cmd_o.rd_second = 1'b1;
              state_d         = S_READ;
            end
          end
          default: begin
            cmd_o.status_code = STAT_OK;
          end
        endcase
      end
      S_READ: begin
        if (sts_i.func == FUNC_MUL) begin
          cmd_o.mul_load = 1'b1;
          state_d        = S_WB;
        end else begin
          cmd_o.div_load = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_WB;
        end
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while held");

  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> state_q == S_WB)
    else $error("remainder unit did not finish into write-back");

  a_wb_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wb |-> !sts_i.short)
    else $error("write-back on a stack with fewer than two words");

endmodule

### rtl/stack_mul_mod_with_bottom_append_unit.sv
// Top level of the stack arithmetic unit: controller plus datapath.
//
// Usage
//   Input channel: in_valid_i / in_stall_o carry one request (func_i, value_i).
//   func_i selects append-at-bottom, multiply or modulo of the top two words.
//   Output channel: out_valid_o / out_stall_i carry one result per request:
//   status_o, top_word_o (zero when empty) and depth_o.
//   A failing request (short stack, zero divisor, full stack) reports its
//   status and leaves the stack untouched. An unused func code is a no-op.
// Sequence
//   Append: check with the bottom write, then the output load.
//   Multiply: check, read of the second word, multiply, write-back, output load.
//   Modulo: check, read of the second word, remainder load, then the restoring
//   remainder unit at one quotient bit per cycle, write-back and output load.
//   One request is in flight at a time; in_stall_o is high while it runs.
// Stalls and reset
//   The result sits in an output register. If the receiver stalls, a new
//   request is still accepted and runs; it waits before its final load
//   until the held result has gone.
//   Reset (rst_ni low, asynchronous) empties the stack and drops any held
//   result; ring storage itself is not cleared.
module stack_mul_mod_with_bottom_append_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] top_word_o,
  output logic [6:0]         depth_o
);
  import smmba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  smmba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  smmba_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .func_i     (func_i),
    .value_i    (value_i),
    .status_o   (status_o),
    .top_word_o (top_word_o),
    .depth_o    (depth_o)
  );

endmodule

### tb/tb_top.sv
// Self-checking bench for the stack arithmetic unit: queued requests, live prediction, checks.
module tb_top;
  import smmba_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  // Slowest request is a modulo; the settle wait is sized to cover one.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_OPS = 283;
  // Code three is not an operation; the unit must pass it by untouched.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] value;
    bit          hold;   // sender waits for every outstanding result first
  } stack_op_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] top_word;
    logic [6:0]  depth;
  } stack_outcome_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         func_i = FUNC_APPEND;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] top_word_o;
  logic [6:0]         depth_o;

  stack_op_t      op_queue[$];
  stack_outcome_t pending_outcomes[$];
  stack_outcome_t want;

  // Shadow of the operand stack, updated as each request is accepted.
  logic [31:0] stack_ring [STACK_DEPTH];
  int unsigned ring_top = 0;
  int unsigned ring_count = 0;

  // Handshake bookkeeping. The two counters move on nonblocking updates so that
  // every reader at a clock edge sees the value from before that edge.
  int unsigned ops_queued = 0;
  int unsigned requests_taken = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned fault_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  bit          took;
  logic [31:0] final_top;

  stack_mul_mod_with_bottom_append_unit #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .top_word_o (top_word_o),
    .depth_o    (depth_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Work out the outcome of one accepted request and queue it for the monitor.
  function automatic void apply_stack_op(input logic [1:0] f, input logic [31:0] v);
    stack_outcome_t res;
    int unsigned    t_idx;
    int unsigned    s_idx;
    logic [31:0]    t;
    logic [31:0]    s;
    logic [31:0]    mag_s;
    logic [31:0]    mag_t;
    logic [31:0]    rem;
    res.status = STAT_OK;
    case (f)
      FUNC_APPEND: begin
        if (ring_count >= STACK_DEPTH) begin
          res.status = STAT_FULL;
        end else if (ring_count == 0) begin
          ring_top = ring_top % STACK_DEPTH;
          stack_ring[ring_top] = v;
          ring_count = 1;
        end else begin
          // new word goes just below the current bottom
          stack_ring[(ring_top + STACK_DEPTH - ring_count) % STACK_DEPTH] = v;
          ring_count++;
        end
      end
      FUNC_MUL, FUNC_MOD: begin
        if (ring_count < 2) begin
          res.status = STAT_SHORT;
        end else begin
          t_idx = ring_top % STACK_DEPTH;
          s_idx = (t_idx + STACK_DEPTH - 1) % STACK_DEPTH;
          t = stack_ring[t_idx];
          s = stack_ring[s_idx];
          if (f == FUNC_MOD && t == '0) begin
            res.status = STAT_DIV_ZERO;
          end else begin
            if (f == FUNC_MUL) begin
              stack_ring[s_idx] = s * t;
            end else begin
              // remainder on magnitudes, sign of the dividend; covers INT_MIN by -1
              mag_s = s[31] ? -s : s;
              mag_t = t[31] ? -t : t;
              rem = mag_s % mag_t;
              stack_ring[s_idx] = s[31] ? -rem : rem;
            end
            ring_top = s_idx;
            ring_count--;
          end
        end
      end
      default: ;
    endcase
    res.top_word = (ring_count == 0) ? '0 : stack_ring[ring_top % STACK_DEPTH];
    res.depth = 7'(ring_count);
    pending_outcomes.push_back(res);
  endfunction

  task automatic queue_op(input logic [1:0] f, input logic [31:0] v, input bit hold);
    stack_op_t op;
    op.func = f;
    op.value = v;
    op.hold = hold;
    op_queue.push_back(op);
    ops_queued++;
  endtask

  // Random requests in bursts: fill runs push the stack to full, crunch runs
  // grind it back down to one word and into short-stack errors, mixed runs
  // sit in between. Zero is kept out of the appended words: once a zero
  // reaches the top it never leaves, so it is saved for the closing requests.
  task automatic queue_random_ops(input int unsigned n, input bit hold_first);
    int unsigned i;
    int unsigned burst_left;
    int unsigned burst_kind;
    int unsigned append_pct;
    logic [1:0]  f;
    logic [31:0] v;
    burst_left = 0;
    burst_kind = 0;
    for (i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_kind = $urandom_range(2);
        burst_left = (burst_kind == 0) ? $urandom_range(90, 40) : $urandom_range(40, 5);
      end
      burst_left--;
      append_pct = (burst_kind == 0) ? 95 : (burst_kind == 1) ? 15 : 50;
      if ($urandom_range(99) < 2) begin
        f = FUNC_UNUSED;
      end else if ($urandom_range(99) < append_pct) begin
        f = FUNC_APPEND;
      end else if ($urandom_range(99) < 55) begin
        f = FUNC_MUL;
      end else begin
        f = FUNC_MOD;
      end
      v = $urandom();
      case ($urandom_range(49))
        0: v = 32'h7FFF_FFFF;
        1: v = 32'h8000_0001;
        default: ;
      endcase
      if (v == '0) begin
        v = 32'h2468_ACE1;
      end
      queue_op(f, v, hold_first && i == 0);
    end
  endtask

  // Returns on a falling edge once every queued request has been taken and answered.
  task automatic wait_settled();
    do begin
      @(posedge clk_i);
    end while (requests_taken != ops_queued || results_seen != ops_queued);
    @(negedge clk_i);
  endtask

  // Request driver: holds a stalled request steady, otherwise presents the
  // next queued one or idles at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        apply_stack_op(func_i, value_i);
        requests_taken <= requests_taken + 1;
      end
      if (!in_valid_i || took) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
            (!op_queue[0].hold || requests_taken + took == results_seen)) begin
          in_valid_i <= 1'b1;
          func_i <= op_queue[0].func;
          value_i <= op_queue[0].value;
          void'(op_queue.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every accepted result against the oldest outstanding outcome.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen <= results_seen + 1;
        if (pending_outcomes.size() == 0) begin
          $display("%0t unexpected result: status %0d top %0d depth %0d",
                   $time, status_o, top_word_o, depth_o);
          fault_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (status_o !== want.status) begin
            $display("%0t status mismatch: expected %0d, actual %0d",
                     $time, want.status, status_o);
            fault_count++;
          end
          if (top_word_o !== want.top_word) begin
            $display("%0t top_word mismatch: expected %0d, actual %0d",
                     $time, $signed(want.top_word), top_word_o);
            fault_count++;
          end
          if (depth_o !== want.depth) begin
            $display("%0t depth mismatch: expected %0d, actual %0d",
                     $time, want.depth, depth_o);
            fault_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_ring[i] = '0;
    end

    // Phase one: sender rarely idles, receiver stalls about half the time.
    sender_idle_pct = 6;
    receiver_idle_pct = 52;

    // Opening requests from the empty stack. Every result here stays clear of
    // zero and of plus or minus one on top, so the random part starts live.
    queue_op(FUNC_MUL, 32'h0000_0000, 1'b0);     // multiply on empty stack
    queue_op(FUNC_MOD, 32'hFFFF_FFFF, 1'b0);     // modulo on empty stack
    queue_op(FUNC_UNUSED, 32'h8000_0000, 1'b0);  // unused code, ignored
    queue_op(FUNC_APPEND, 32'h7FFF_FFFF, 1'b0);  // append to empty stack
    queue_op(FUNC_MUL, 32'h0000_0000, 1'b0);     // one word only
    queue_op(FUNC_MOD, 32'h0000_0000, 1'b0);     // one word only
    queue_op(FUNC_APPEND, 32'h0000_0003, 1'b0);
    queue_op(FUNC_MUL, 32'hFFFF_FFFF, 1'b0);     // wraps past 32 bits
    queue_op(FUNC_APPEND, 32'hFFFF_FF9C, 1'b0);
    queue_op(FUNC_MOD, 32'h0000_0000, 1'b0);     // small negative by large positive
    queue_op(FUNC_APPEND, 32'h7FFF_FFFF, 1'b0);
    queue_op(FUNC_MOD, 32'h0000_0000, 1'b0);     // positive by negative
    queue_op(FUNC_APPEND, 32'h8000_0001, 1'b0);
    queue_op(FUNC_MOD, 32'h0000_0000, 1'b0);     // negative by positive
    queue_op(FUNC_APPEND, 32'h0000_0007, 1'b0);
    queue_op(FUNC_MOD, 32'h0000_0000, 1'b0);     // dividend smaller than divisor
    queue_op(FUNC_APPEND, 32'h1234_5677, 1'b0);
    queue_op(FUNC_MUL, 32'h0000_0000, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_random_ops(PHASE_OPS, 1'b0);
    wait_settled();

    // Phase two: roles swapped; the first request waits for a fully drained unit.
    sender_idle_pct = 52;
    receiver_idle_pct = 6;
    queue_random_ops(PHASE_OPS, 1'b1);
    wait_settled();

    // Phase three: back to back on both sides.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    queue_random_ops(PHASE_OPS, 1'b0);
    wait_settled();

    // Closing requests: fold the stack down to a single word, steer the top to
    // minus one, then the zero-making cases that end all useful arithmetic.
    if (ring_count > 1) begin
      repeat (ring_count - 1) queue_op(FUNC_MUL, $urandom(), 1'b0);
    end
    wait_settled();
    final_top = stack_ring[ring_top % STACK_DEPTH];
    if (final_top == 32'h0000_0001) begin
      queue_op(FUNC_APPEND, 32'hFFFF_FFFF, 1'b0);
      queue_op(FUNC_MUL, 32'h0000_0000, 1'b0);
    end else if (final_top != '0 && final_top != 32'hFFFF_FFFF) begin
      queue_op(FUNC_APPEND, 32'hFFFF_FFFF, 1'b0);
      queue_op(FUNC_MOD, 32'h0000_0000, 1'b0);  // minus one keeps its sign
    end
    queue_op(FUNC_APPEND, 32'h8000_0000, 1'b0);
    queue_op(FUNC_MOD, 32'h0000_0000, 1'b0);      // most negative word by minus one
    queue_op(FUNC_APPEND, 32'h0000_0000, 1'b0);
    queue_op(FUNC_MOD, 32'h0000_0000, 1'b0);      // division by zero
    queue_op(FUNC_MUL, 32'h0000_0000, 1'b0);
    queue_op(FUNC_UNUSED, 32'h7FFF_FFFF, 1'b0);
    wait_settled();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && pending_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/smmba_pkg.sv
rtl/smmba_dp.sv
rtl/smmba_ctrl.sv
rtl/stack_mul_mod_with_bottom_append_unit.sv
tb/tb_top.sv
